>>> rtl/radconv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radconv_pkg: shared types and constants of the radix converter
// Widths, digit counts, register indexes and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package radconv_pkg;

  localparam int SRC_W          = 63;  // width of the input number
  localparam int BASE_W         = 4;   // width of a radix register
  localparam int DIGIT_W        = 4;   // width of one digit
  localparam int BCD_DIGITS     = 19;  // decimal digits of a 63-bit number
  localparam int OUT_DIGITS     = 63;  // target digits held (radix 2 worst case)
  localparam int MAX_OUT_DIGITS = 64;
  localparam int DIGIT_CAP      = (MAX_OUT_DIGITS < OUT_DIGITS) ? MAX_OUT_DIGITS : OUT_DIGITS;
  localparam int CNT_W          = 6;   // step counter, counts up to 62
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'd1;

  localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 4'd10;
  localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 4'd10;
  localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 4'd2;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // start a new word: clear working registers
    logic bcd_step;    // one binary-to-decimal shift
    logic horner_step; // fold one decimal digit into the value
    logic conv_step;   // shift one value bit into the target digits
    logic emit_step;   // examine and shift out the top target digit
    logic emit_error;  // send the error result
    logic final_pos;   // emit step is at the least significant digit
    logic high_pos;    // emit step is at a position beyond the digit cap
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bases_ok;    // both radix registers lie in 2..10
    logic digit_bad;   // current decimal digit is not below the source radix
    logic emit_abort;  // result needs more digits than the cap allows
  } status_t;

endpackage

>>> rtl/radconv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radconv_ctrl: sequencing controller of the radix converter
// Steps a word through decimal split, Horner evaluation, target radix
// conversion and digit emission, counting the steps of each phase.
// ----------------------------------------------------------------------------
module radconv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  radconv_pkg::status_t status,
  output radconv_pkg::cmd_t    cmd
);
  import radconv_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BCD  = 3'd1;
  localparam logic [2:0] ST_HORN = 3'd2;
  localparam logic [2:0] ST_CONV = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             cnt_zero;

  assign busy     = (state != ST_IDLE);
  assign cnt_zero = (cnt == '0);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (status.bases_ok) begin
            cmd.load   = 1'b1;
            state_next = ST_BCD;
            cnt_next   = CNT_W'(SRC_W - 1);
          end else begin
            cmd.emit_error = 1'b1;
          end
        end
      end
      ST_BCD: begin
        cmd.bcd_step = 1'b1;
        if (cnt_zero) begin
          state_next = ST_HORN;
          cnt_next   = CNT_W'(BCD_DIGITS - 1);
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_HORN: begin
        if (status.digit_bad) begin
          cmd.emit_error = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.horner_step = 1'b1;
          if (cnt_zero) begin
            state_next = ST_CONV;
            cnt_next   = CNT_W'(SRC_W - 1);
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (cnt_zero) begin
          state_next = ST_EMIT;
          cnt_next   = CNT_W'(OUT_DIGITS - 1);
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        cmd.final_pos = cnt_zero;
        cmd.high_pos  = ({1'b0, cnt} >= (CNT_W + 1)'(DIGIT_CAP));
        if (cnt_zero || status.emit_abort) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> rtl/radconv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radconv_dp: datapath of the radix converter
// Radix registers, binary-to-decimal shifter, Horner accumulator, target
// radix digit line with carry-chain doubling, and the result register.
// ----------------------------------------------------------------------------
module radconv_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [radconv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [radconv_pkg::BASE_W-1:0]    cfg_data,
  input  logic [radconv_pkg::SRC_W-1:0]     source_number,
  input  radconv_pkg::cmd_t                 cmd,
  output radconv_pkg::status_t              status,
  output logic                              strobe,
  output logic [radconv_pkg::DIGIT_W-1:0]   digit,
  output logic                              last,
  output logic                              failed
);
  import radconv_pkg::*;

  logic [BASE_W-1:0] source_base, target_base;
  logic [SRC_W-1:0]  shreg;
  logic [SRC_W-1:0]  acc;
  digit_t            bcd  [BCD_DIGITS];
  digit_t            tdig [OUT_DIGITS];
  logic              started;

  // Binary-to-decimal step: digits of five or more get three added first.
  digit_t bcd_adj  [BCD_DIGITS];
  digit_t bcd_next [BCD_DIGITS];

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
    bcd_next[0] = {bcd_adj[0][DIGIT_W-2:0], shreg[SRC_W-1]};
    for (int i = 1; i < BCD_DIGITS; i++) begin
      bcd_next[i] = {bcd_adj[i][DIGIT_W-2:0], bcd_adj[i-1][DIGIT_W-1]};
    end
  end

  // Horner step on the top decimal digit.
  digit_t                   dec_top;
  logic [SRC_W+BASE_W-1:0]  prod;

  assign dec_top = bcd[BCD_DIGITS-1];
  assign prod    = {{BASE_W{1'b0}}, acc} * {{SRC_W{1'b0}}, source_base};

  // Doubling of the target digit line plus one incoming bit. A digit
  // generates a carry when twice it reaches the radix, and propagates one
  // when twice it is one below the radix; the carries come out of one add.
  logic [OUT_DIGITS-1:0] gen, prop;
  logic [OUT_DIGITS:0]   csum, carry;
  logic [DIGIT_W:0]      tb_ext, tb_m1;
  digit_t                tdig_next [OUT_DIGITS];

  assign tb_ext = {1'b0, target_base};
  assign tb_m1  = tb_ext - 1'b1;

  always_comb begin
    for (int i = 0; i < OUT_DIGITS; i++) begin
      gen[i]  = ({tdig[i], 1'b0} >= tb_ext);
      prop[i] = ({tdig[i], 1'b0} == tb_m1);
    end
    csum  = {1'b0, gen | prop} + {1'b0, gen} + {{OUT_DIGITS{1'b0}}, acc[SRC_W-1]};
    carry = csum ^ {1'b0, gen | prop} ^ {1'b0, gen};
    for (int i = 0; i < OUT_DIGITS; i++) begin
      tdig_next[i] = DIGIT_W'({tdig[i], 1'b0} + {{DIGIT_W{1'b0}}, carry[i]}
                              - (carry[i+1] ? tb_ext : '0));
    end
  end

  // Emission of the top target digit.
  digit_t emit_top;
  logic   emit_show;

  assign emit_top  = tdig[OUT_DIGITS-1];
  assign emit_show = started || (emit_top != '0) || cmd.final_pos;

  assign status.bases_ok = (source_base >= BASE_MIN) && (source_base <= BASE_MAX) &&
                           (target_base >= BASE_MIN) && (target_base <= BASE_MAX);
  assign status.digit_bad  = (dec_top >= source_base);
  assign status.emit_abort = cmd.emit_step && emit_show && !started && cmd.high_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= SOURCE_BASE_RESET;
      target_base <= TARGET_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_BASE: source_base <= cfg_data;
        REG_TARGET_BASE: target_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= source_number;
      acc   <= '0;
      for (int i = 0; i < BCD_DIGITS; i++) bcd[i] <= '0;
      for (int i = 0; i < OUT_DIGITS; i++) tdig[i] <= '0;
    end
    if (cmd.bcd_step) begin
      shreg <= {shreg[SRC_W-2:0], 1'b0};
      for (int i = 0; i < BCD_DIGITS; i++) bcd[i] <= bcd_next[i];
    end
    if (cmd.horner_step) begin
      acc    <= prod[SRC_W-1:0] + {{(SRC_W-DIGIT_W){1'b0}}, dec_top};
      bcd[0] <= '0;
      for (int i = 1; i < BCD_DIGITS; i++) bcd[i] <= bcd[i-1];
    end
    if (cmd.conv_step) begin
      acc <= {acc[SRC_W-2:0], 1'b0};
      for (int i = 0; i < OUT_DIGITS; i++) tdig[i] <= tdig_next[i];
    end
    if (cmd.emit_step) begin
      tdig[0] <= '0;
      for (int i = 1; i < OUT_DIGITS; i++) tdig[i] <= tdig[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.load) begin
        started <= 1'b0;
      end
      if (cmd.emit_error || status.emit_abort) begin
        strobe <= 1'b1;
      end else if (cmd.emit_step && emit_show) begin
        strobe  <= 1'b1;
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_error || status.emit_abort) begin
      digit  <= '0;
      last   <= 1'b1;
      failed <= 1'b1;
    end else if (cmd.emit_step && emit_show) begin
      digit  <= emit_top;
      last   <= cmd.final_pos;
      failed <= 1'b0;
    end
  end

endmodule

>>> rtl/radix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_converter: base conversion between radices 2 and 10
// Reads the decimal digits of a number as digits in the source radix and
// emits the value's digits in the target radix, most significant first.
// ----------------------------------------------------------------------------
//
// Channel        Signals                                   Transfer
// -------------  ----------------------------------------  -------------------
// input word     start, busy, source_number                start && !busy
// result word    strobe, digit, last, failed               strobe (one cycle)
// configuration  cfg_we, cfg_index, cfg_data               cfg_we
//
// An accepted word runs through four phases, one step per cycle each:
// binary-to-decimal shifting, 19 Horner steps (one 63 x 4 multiply-add
// per step), shifting the value into the target digit line, and scanning
// that line from the top, with busy high throughout. Each result word is
// registered and appears in the cycle after its scan step. A digit not
// below the source radix ends the word at the Horner step that finds it;
// the error word appears in the next cycle, in which busy is low again.
// Invalid radices give the error word in the cycle after acceptance and
// busy never rises. Reset is synchronous and returns both radices to
// their defaults (10 and 2). The receiver cannot stall the results.
//
// The controller sequences the phases and counts their steps; the datapath
// holds the radix registers, the working shift lines and the result
// register, and reports radix and digit checks back as status.
// ----------------------------------------------------------------------------
module radix_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [radconv_pkg::SRC_W-1:0]     source_number,
  input  logic                              cfg_we,
  input  logic [radconv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [radconv_pkg::BASE_W-1:0]    cfg_data,
  output logic                              strobe,
  output logic [radconv_pkg::DIGIT_W-1:0]   digit,
  output logic                              last,
  output logic                              failed
);
  import radconv_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: turns the start request and the datapath status into one
  // command word per cycle.
  radconv_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath: configuration registers, conversion shift lines and the
  // registered result word.
  radconv_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .source_number (source_number),
    .cmd           (cmd),
    .status        (status),
    .strobe        (strobe),
    .digit         (digit),
    .last          (last),
    .failed        (failed)
  );

endmodule

>>> test/radix_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_converter_test: self-checking bench for the radix converter
// Sends numbers through the command port and keeps a model of the
// conversion. Each digit word on the result port is compared with the oldest
// expected one. A short table of corner cases comes first. Random phases at
// several radix settings follow, with bursts of idle time on the sender.
// ----------------------------------------------------------------------------
module radix_converter_test;
  import radconv_pkg::*;

  localparam int NUM_DIRECTED    = 25;
  localparam int NUM_PHASES      = 13;
  localparam int WORDS_PER_PHASE = 31;
  localparam int CALM_PHASES     = 2;      // closing phases run without idling
  localparam int SETTLE_CYCLES   = 240;    // a little over one full conversion
  localparam int DRAIN_LIMIT     = 20000;
  localparam logic [SRC_W-1:0] SRC_MAX = {SRC_W{1'b1}};

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {CHECK_PREDICTED, CHECK_DIGITS, CHECK_ERROR} check_t;

  typedef struct packed {
    digit_t digit;
    logic   last;
    logic   failed;
  } result_word_t;

  // One directed case: the radices to set, the number to send and the way to
  // check it. For CHECK_DIGITS the decimal digits of spelled are the expected
  // target digits, most significant first.
  typedef struct packed {
    logic [BASE_W-1:0] src;
    logic [BASE_W-1:0] dst;
    logic [SRC_W-1:0]  number;
    check_t            check;
    logic [63:0]       spelled;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [SRC_W-1:0]     source_number;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BASE_W-1:0]    cfg_data;
  logic                 strobe;
  digit_t               digit;
  logic                 last;
  logic                 failed;

  // Shadow copies of the two radix registers, updated as they are written.
  logic [BASE_W-1:0] src_radix;
  logic [BASE_W-1:0] dst_radix;

  // Digit words still owed by the block, oldest first.
  result_word_t expected_digits[$];
  int           mismatches;
  stim_row_t    stim_rows [NUM_DIRECTED];

  radix_converter dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .source_number (source_number),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .strobe        (strobe),
    .digit         (digit),
    .last          (last),
    .failed        (failed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A run that hangs ends here. A correct run needs well under a fifth of this.
  initial begin
    #8_000_000;
    $display("radix_converter: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit radix_valid(input logic [BASE_W-1:0] r);
    return r >= BASE_MIN && r <= BASE_MAX;
  endfunction

  function automatic stim_row_t stim_row(input logic [BASE_W-1:0] src,
                                         input logic [BASE_W-1:0] dst,
                                         input logic [SRC_W-1:0] number,
                                         input check_t check,
                                         input logic [63:0] spelled);
    stim_row_t row;
    row.src     = src;
    row.dst     = dst;
    row.number  = number;
    row.check   = check;
    row.spelled = spelled;
    return row;
  endfunction

  // Works out the digit words that one number gives under the current
  // radices and queues them. A bad radix or a bad digit gives a single error
  // word. Zero gives a single digit 0.
  task automatic convert_radix(input logic [SRC_W-1:0] number);
    logic [63:0] rest;
    logic [63:0] value;
    digit_t      dec [BCD_DIGITS];
    digit_t      out_dig [OUT_DIGITS];
    int          nd;
    int          nt;
    bit          bad;
    nd  = 0;
    nt  = 0;
    bad = !radix_valid(src_radix) || !radix_valid(dst_radix);
    rest = {1'b0, number};
    // Split into decimal digits, least significant first. Each one must lie
    // below the source radix.
    while (rest != 0 && !bad) begin
      if (rest % 10 >= src_radix) begin
        bad = 1'b1;
      end else begin
        dec[nd] = digit_t'(rest % 10);
        nd++;
        rest = rest / 10;
      end
    end
    // Horner's rule, most significant digit first.
    value = 0;
    for (int k = nd - 1; k >= 0 && !bad; k--) begin
      value = value * src_radix + dec[k];
    end
    if (!bad && value == 0) begin
      out_dig[0] = '0;
      nt = 1;
    end
    while (!bad && value != 0) begin
      if (nt >= DIGIT_CAP) begin
        bad = 1'b1;
      end else begin
        out_dig[nt] = digit_t'(value % dst_radix);
        nt++;
        value = value / dst_radix;
      end
    end
    if (bad) begin
      expected_digits.push_back({digit_t'(0), 1'b1, 1'b1});
    end else begin
      for (int k = 0; k < nt; k++) begin
        expected_digits.push_back({out_dig[nt - 1 - k], k == nt - 1, 1'b0});
      end
    end
  endtask

  // Builds a number whose decimal digits are legal in the given radix. With
  // spoil set and a radix below 10, one digit is pushed to the radix or
  // above, so the block must refuse the number.
  function automatic logic [SRC_W-1:0] digits_in_radix(input logic [BASE_W-1:0] radix,
                                                       input bit spoil);
    int          ndig;
    int          bad_at;
    int          hi;
    int          eff;
    logic [63:0] acc;
    eff    = radix_valid(radix) ? int'(radix) : int'(BASE_MAX);
    ndig   = $urandom_range(BCD_DIGITS, 1);
    bad_at = -1;
    if (spoil && eff < BASE_MAX) begin
      bad_at = $urandom_range((ndig == BCD_DIGITS) ? BCD_DIGITS - 2 : ndig - 1, 0);
    end
    acc = 0;
    for (int k = ndig - 1; k >= 0; k--) begin
      hi = eff - 1;
      // A leading digit of 8 or less keeps a 19-digit number below 2**63.
      if (k == BCD_DIGITS - 1 && hi > 8) begin
        hi = 8;
      end
      if (k == bad_at) begin
        acc = acc * 10 + $urandom_range(9, eff);
      end else begin
        acc = acc * 10 + $urandom_range(hi, 0);
      end
    end
    return acc[SRC_W-1:0];
  endfunction

  // Raises start with the next number and holds it until the block takes the
  // word. This returns in the time step of the accepting edge.
  task automatic send_word(input logic [SRC_W-1:0] n);
    start         <= 1'b1;
    source_number <= n;
    do @(posedge clk); while (busy);
  endtask

  // Sometimes the sender goes quiet after a word. Half of these gaps begin
  // while the block is still converting and half once it is free again, so
  // that they fall at every point of its work.
  task automatic sender_idle(input bit allow);
    if (allow && $urandom_range(99, 0) < 30) begin
      start         <= 1'b0;
      source_number <= SRC_W'({$urandom, $urandom});
      if ($urandom_range(1, 0) != 0) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  // The radices may only change while the block is idle. So this task waits
  // until every digit word owed has arrived and busy is low. It then writes
  // both registers, the source radix first and then the target radix.
  task automatic set_bases(input logic [BASE_W-1:0] sb, input logic [BASE_W-1:0] tb);
    start <= 1'b0;
    while (expected_digits.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SOURCE_BASE;
    cfg_data  <= sb;
    @(posedge clk);
    src_radix = sb;
    cfg_index <= REG_TARGET_BASE;
    cfg_data  <= tb;
    @(posedge clk);
    dst_radix = tb;
    cfg_we <= 1'b0;
  endtask

  // Every strobed word is taken at the edge that ends its cycle and compared,
  // field by field, with the oldest word still expected.
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && strobe !== 1'b0) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("result word (digit %0d last %b failed %b) not expected",
                                  digit, last, failed));
      end else begin
        want = expected_digits.pop_front();
        if (digit !== want.digit) begin
          report_mismatch($sformatf("digit %0d, expected %0d", digit, want.digit));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
        end
        if (failed !== want.failed) begin
          report_mismatch($sformatf("failed %b, expected %b", failed, want.failed));
        end
      end
    end
  end

  initial begin : stimulus
    logic [63:0]       spelled;
    digit_t            spelled_dig [20];
    int                ns;
    int                w;
    int                pick;
    bit                calm;
    logic [BASE_W-1:0] sb;
    logic [BASE_W-1:0] tb;
    logic [SRC_W-1:0]  n;

    rst           = 1'b1;
    start         = 1'b0;
    source_number = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_SOURCE_BASE;
    cfg_data      = '0;
    mismatches    = 0;
    src_radix     = SOURCE_BASE_RESET;
    dst_radix     = TARGET_BASE_RESET;

    // The first rows run at the reset radices (decimal to binary), so no
    // register is written before them. The bad-radix rows cover both ends of
    // the 4-bit range and the values just outside 2..10.
    stim_rows[0]  = stim_row(4'd10, 4'd2,  63'd5, CHECK_DIGITS, 64'd101);
    stim_rows[1]  = stim_row(4'd10, 4'd2,  63'd0, CHECK_DIGITS, 64'd0);
    stim_rows[2]  = stim_row(4'd10, 4'd2,  SRC_MAX, CHECK_PREDICTED, 64'd0);
    stim_rows[3]  = stim_row(4'd10, 4'd10, SRC_MAX, CHECK_DIGITS,
                             64'd9223372036854775807);
    stim_rows[4]  = stim_row(4'd2,  4'd10, 63'd1111111111111111111, CHECK_DIGITS,
                             64'd524287);
    stim_rows[5]  = stim_row(4'd2,  4'd10, 63'd1000000000000000000, CHECK_DIGITS,
                             64'd262144);
    stim_rows[6]  = stim_row(4'd2,  4'd2,  63'd1011, CHECK_DIGITS, 64'd1011);
    stim_rows[7]  = stim_row(4'd2,  4'd2,  63'd0, CHECK_DIGITS, 64'd0);
    stim_rows[8]  = stim_row(4'd2,  4'd10, 63'd2, CHECK_ERROR, 64'd0);
    stim_rows[9]  = stim_row(4'd9,  4'd10, 63'd9, CHECK_ERROR, 64'd0);
    stim_rows[10] = stim_row(4'd9,  4'd10, 63'd8888888888888888888, CHECK_PREDICTED, 64'd0);
    stim_rows[11] = stim_row(4'd5,  4'd10, 63'd5000000000000000000, CHECK_ERROR, 64'd0);
    stim_rows[12] = stim_row(4'd5,  4'd10, 63'd4, CHECK_DIGITS, 64'd4);
    stim_rows[13] = stim_row(4'd1,  4'd10, 63'd0, CHECK_ERROR, 64'd0);
    stim_rows[14] = stim_row(4'd0,  4'd10, 63'd5, CHECK_ERROR, 64'd0);
    stim_rows[15] = stim_row(4'd11, 4'd10, 63'd5, CHECK_ERROR, 64'd0);
    stim_rows[16] = stim_row(4'd15, 4'd10, 63'd5, CHECK_ERROR, 64'd0);
    stim_rows[17] = stim_row(4'd10, 4'd1,  63'd5, CHECK_ERROR, 64'd0);
    stim_rows[18] = stim_row(4'd10, 4'd0,  63'd0, CHECK_ERROR, 64'd0);
    stim_rows[19] = stim_row(4'd10, 4'd11, 63'd7, CHECK_ERROR, 64'd0);
    stim_rows[20] = stim_row(4'd10, 4'd15, 63'd7, CHECK_ERROR, 64'd0);
    stim_rows[21] = stim_row(4'd3,  4'd7,  63'd2101221, CHECK_PREDICTED, 64'd0);
    stim_rows[22] = stim_row(4'd10, 4'd9,  SRC_MAX, CHECK_PREDICTED, 64'd0);
    stim_rows[23] = stim_row(4'd8,  4'd3,  63'd7777777777777777777, CHECK_PREDICTED, 64'd0);
    stim_rows[24] = stim_row(4'd10, 4'd10, 63'd0, CHECK_DIGITS, 64'd0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The expected words of a row are queued in the time step
    // of its accepting edge, so they are in place before the first result.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (stim_rows[i].src != src_radix || stim_rows[i].dst != dst_radix) begin
        set_bases(stim_rows[i].src, stim_rows[i].dst);
      end
      send_word(stim_rows[i].number);
      case (stim_rows[i].check)
        CHECK_ERROR: begin
          expected_digits.push_back({digit_t'(0), 1'b1, 1'b1});
        end
        CHECK_DIGITS: begin
          spelled = stim_rows[i].spelled;
          ns = 0;
          do begin
            spelled_dig[ns] = digit_t'(spelled % 10);
            ns++;
            spelled = spelled / 10;
          end while (spelled != 0);
          for (int k = ns - 1; k >= 0; k--) begin
            expected_digits.push_back({spelled_dig[k], k == 0, 1'b0});
          end
        end
        default: begin
          convert_radix(stim_rows[i].number);
        end
      endcase
      sender_idle(1'b1);
    end

    // Random part. The opening phases pin the radices to their extremes and
    // to two illegal pairs. The later ones draw mostly legal radices. Most
    // words are well formed, some carry one digit too large for the source
    // radix, and the rest are raw 63-bit noise.
    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p >= NUM_PHASES - CALM_PHASES);
      case (p)
        0: begin
          sb = 4'd2;
          tb = 4'd2;
        end
        1: begin
          sb = 4'd10;
          tb = 4'd10;
        end
        2: begin
          sb = 4'd2;
          tb = 4'd10;
        end
        3: begin
          sb = 4'd10;
          tb = 4'd2;
        end
        4: begin
          sb = 4'd0;
          tb = 4'd15;
        end
        5: begin
          sb = 4'd15;
          tb = 4'd1;
        end
        default: begin
          if (!calm && $urandom_range(99, 0) < 15) begin
            sb = BASE_W'($urandom_range(15, 0));
            tb = BASE_W'($urandom_range(15, 0));
          end else begin
            sb = BASE_W'($urandom_range(BASE_MAX, BASE_MIN));
            tb = BASE_W'($urandom_range(BASE_MAX, BASE_MIN));
          end
        end
      endcase
      set_bases(sb, tb);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 80) begin
          n = digits_in_radix(src_radix, 1'b0);
        end else if (pick < 90) begin
          n = digits_in_radix(src_radix, 1'b1);
        end else begin
          n = SRC_W'({$urandom, $urandom});
        end
        send_word(n);
        convert_radix(n);
        sender_idle(!calm);
      end
    end

    // Let every owed word arrive. Then wait one conversion longer so that a
    // stray word would still be caught.
    start <= 1'b0;
    w = 0;
    while ((expected_digits.size() != 0 || busy) && w < DRAIN_LIMIT) begin
      @(posedge clk);
      w++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_digits.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", expected_digits.size()));
    end

    if (mismatches == 0) begin
      $display("radix_converter: match");
    end else begin
      $display("radix_converter: mismatch");
    end
    $finish;
  end

endmodule
